// ===== src/bmhq_pkg.sv =====
// Package for the binary max-heap queue: beat payload types, codes and the cell control bundle.
// No dependencies. The cell, top-level and checker files in src use it by scoped names.
package bmhq_pkg;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned COUNT_W = 7;

  // Operation codes carried in the action field.
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef struct packed {
    logic action;
    key_t key_in;
  } req_item_t;

  typedef struct packed {
    status_t              status;
    key_t                 max_out;
    logic [COUNT_W-1:0]   entry_count;
  } resp_item_t;

  // Broadcast control for the row of cells.
  typedef struct packed {
    logic ins;
    logic rem;
    key_t key;
  } cell_ctl_t;

endpackage

// ===== src/bmhq_chan.sv =====
// Valid/ready channel interface carrying one payload beat.
// Depends on nothing; the payload type is set where the channel is instantiated.
interface bmhq_chan #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/bmhq_cell.sv =====
// One cell of the sorted key row: holds one key, largest keys toward cell 0.
// Depends on bmhq_pkg.
module bmhq_cell (
  input  logic                clk,
  input  bmhq_pkg::cell_ctl_t ctl,
  input  logic                occ,
  input  bmhq_pkg::key_t      up_key,
  input  logic                up_gt,
  input  bmhq_pkg::key_t      down_key,
  output logic                gt,
  output bmhq_pkg::key_t      key
);

  bmhq_pkg::key_t key_next;

  // New key belongs at or above this cell when the cell is empty or smaller.
  assign gt = !occ || (ctl.key > key);

  always_comb begin
    key_next = key;
    if (ctl.ins) begin
      if (up_gt) begin
        key_next = up_key;
      end else if (gt) begin
        key_next = ctl.key;
      end
    end else if (ctl.rem) begin
      key_next = down_key;
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
  end

endmodule

// ===== src/binary_max_heap_queue.sv =====
// Top level of the max priority queue of signed 32-bit keys.
// Depends on bmhq_pkg, bmhq_chan and bmhq_cell.
//
//   channel  dir  payload fields                     beat
//   req      in   action, key_in                     one insert or remove
//   resp     out  status, max_out, entry_count       one result per req beat
//
// Cycles: a result is registered at the edge that takes the request; one item per
//   cycle while resp is drained. The rate is set by the cell row, which does a whole
//   insert or remove in one compare-and-shift.
// Reset: rst clears the entry count and the result valid flag; the result data and
//   the key cells hold no reset and cells beyond the count are never read. req
//   holds off for as long as rst is high.
// Stalls: req stays ready while a result waits, as long as that result is taken
//   in the same cycle; otherwise req holds off until resp drains.
module binary_max_heap_queue #(
  parameter int unsigned DEPTH = 64
) (
  input logic     clk,
  input logic     rst,
  bmhq_chan.sink   req,
  bmhq_chan.source resp
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  logic                 req_fire;
  logic                 is_full;
  logic                 is_empty;
  bmhq_pkg::cell_ctl_t  ctl;
  bmhq_pkg::resp_item_t resp_next;

  // Cell row taps: gt and key per cell.
  logic                 cell_gt  [DEPTH];
  bmhq_pkg::key_t       cell_key [DEPTH];
  logic [DEPTH-1:0]     occ;

  // Take a new beat whenever the result register is free or being emptied,
  // never while in reset.
  assign req.ready = !rst && (!resp.valid || resp.ready);
  assign req_fire  = req.valid && req.ready;

  assign is_full  = (count == CW'(DEPTH));
  assign is_empty = (count == '0);

  // Drop inserts into a full row and removes from an empty one.
  assign ctl.ins = req_fire && (req.data.action == bmhq_pkg::ACT_INSERT) && !is_full;
  assign ctl.rem = req_fire && (req.data.action == bmhq_pkg::ACT_REMOVE) && !is_empty;
  assign ctl.key = req.data.key_in;

  always_comb begin
    count_next = count;
    if (ctl.ins) begin
      count_next = count + CW'(1);
    end else if (ctl.rem) begin
      count_next = count - CW'(1);
    end
  end

  // Build the result: status from the request kind and fill, max from cell 0.
  always_comb begin
    resp_next.status      = bmhq_pkg::STATUS_OK;
    resp_next.max_out     = '0;
    resp_next.entry_count = bmhq_pkg::COUNT_W'(count_next);
    if (req.data.action == bmhq_pkg::ACT_INSERT) begin
      if (is_full) begin
        resp_next.status = bmhq_pkg::STATUS_FULL;
      end
    end else begin
      if (is_empty) begin
        resp_next.status = bmhq_pkg::STATUS_EMPTY;
      end else begin
        resp_next.max_out = cell_key[0];
      end
    end
  end

  // Row of cells, sorted descending; each cell shifts keys to and from its neighbors.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    bmhq_pkg::key_t up_key;
    logic           up_gt;
    bmhq_pkg::key_t down_key;

    assign occ[i] = (CW'(i) < count);

    if (i == 0) begin : g_head
      assign up_key = ctl.key;
      assign up_gt  = 1'b0;
    end else begin : g_body
      assign up_key = cell_key[i-1];
      assign up_gt  = cell_gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign down_key = cell_key[i];
    end else begin : g_mid
      assign down_key = cell_key[i+1];
    end

    bmhq_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .occ      (occ[i]),
      .up_key   (up_key),
      .up_gt    (up_gt),
      .down_key (down_key),
      .gt       (cell_gt[i]),
      .key      (cell_key[i])
    );
  end

  // Hold count and result register; advance on each accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      resp.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (req_fire) begin
        resp.valid <= 1'b1;
      end else if (resp.ready) begin
        resp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      resp.data <= resp_next;
    end
  end

endmodule

// ===== src/bmhq_chk.sv =====
// Port-level checker for the max priority queue, bound to the top level.
// Depends on bmhq_pkg and binary_max_heap_queue.
module bmhq_chk #(
  parameter int unsigned DEPTH = 64
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_ready,
  input logic                 resp_valid,
  input logic                 resp_ready,
  input bmhq_pkg::resp_item_t resp_data
);

  // Every accepted request shows a result on the next cycle.
  a_req_to_resp: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> resp_valid)
    else $error("accepted request gave no result");

  // A stalled result holds its beat.
  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    resp_valid && !resp_ready |=> resp_valid && $stable(resp_data))
    else $error("stalled result changed");

  // Empty remove reports nothing removed and nothing held.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    resp_valid && (resp_data.status == bmhq_pkg::STATUS_EMPTY) |->
      (resp_data.max_out == '0) && (resp_data.entry_count == '0))
    else $error("empty status with data");

  // Dropped insert reports the full count.
  a_full: assert property (@(posedge clk) disable iff (rst)
    resp_valid && (resp_data.status == bmhq_pkg::STATUS_FULL) |->
      (resp_data.max_out == '0) &&
      (resp_data.entry_count == bmhq_pkg::COUNT_W'(DEPTH)))
    else $error("full status with wrong count");

endmodule

bind binary_max_heap_queue bmhq_chk #(.DEPTH(DEPTH)) u_bmhq_chk (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .resp_valid (resp.valid),
  .resp_ready (resp.ready),
  .resp_data  (resp.data)
);
